/* rtl/ptwa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptwa_pkg
// shared types and constants for the peer table with aging
// ----------------------------------------------------------------------------
package ptwa_pkg;

    // field widths
    localparam int ADDR_W   = 48;
    localparam int POWER_W  = 20;
    localparam int PRIO_W   = 8;
    localparam int TIME_W   = 32;
    localparam int TOTAL_W  = 25;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // defaults and limits
    localparam int                 TABLE_DEPTH_DEFAULT = 32;
    localparam logic [TIME_W-1:0]  STALE_LIMIT_RESET   = 32'd6000;
    localparam logic [COUNT_W-1:0] COUNT_MAX           = 6'd63;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX           = 25'h1FF_FFFF;

    // item commands
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_PURGE  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_PURGED   = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY
    } t_state;

    // input item
    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0]  node_addr;
        logic [POWER_W-1:0] power_centi;
        logic [PRIO_W-1:0]  priority_req;
        logic [TIME_W-1:0]  now_ms;
    } t_in_item;

    // result item
    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] node_count;
        logic [TOTAL_W-1:0] total_centi;
        logic [TIME_W-1:0]  report_interval_ms;
        logic [COUNT_W-1:0] purged_count;
    } t_out_item;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [POWER_W-1:0] power;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  last_seen;
        logic [TIME_W-1:0]  prev_seen;
    } t_entry;

    // age unit result
    typedef struct packed {
        logic [TIME_W-1:0] diff;
        logic              stale;
    } t_age_res;

endpackage
`default_nettype wire

/* rtl/ptwa_age_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptwa_age_unit
// shared wrapping time subtractor with stale-limit compare; serves the
// per-entry age check during a purge and the report interval on an update
// ----------------------------------------------------------------------------
module ptwa_age_unit
    import ptwa_pkg::*;
(
    input  wire logic [TIME_W-1:0] i_now,
    input  wire logic [TIME_W-1:0] i_then,
    input  wire logic [TIME_W-1:0] i_limit,
    output t_age_res               o_res
);

    logic [TIME_W-1:0] diff;

    // modulo 2^32 difference and compare against the limit
    assign diff        = i_now - i_then;
    assign o_res.diff  = diff;
    assign o_res.stale = (diff > i_limit);

endmodule
`default_nettype wire

/* rtl/peer_table_with_aging.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// peer_table_with_aging
// table of consumer nodes keyed by 48-bit address, with purge of stale nodes
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one t_in_item per transfer:
// a report (cmd 0) updates or inserts the node, a purge (cmd 1) drops every
// node whose age exceeds the stale limit. Each item gives one t_out_item on
// o_out_valid / i_out_stall. The user must write the stale limit through
// i_cfg_valid / o_cfg_ready only while no item is in flight; the block does
// not enforce it. The sequencer reads the entry memory once per entry, one
// entry per cycle through its registered read port, then drains the read
// pipe and applies the update. A new item is taken only after the update of
// the last one has been applied. The result sits in an output register, so
// the next item can be taken while it waits; if it is still stalled when
// the next result is ready the sequencer holds in its final step.
// Reset clears all valid bits, the running total and the output valid bit
// and loads the stale limit with 6000 ms; entry contents need no clearing.
// ----------------------------------------------------------------------------
module peer_table_with_aging
    import ptwa_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // item input
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_data,
    // result output
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data,
    // stale limit write
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [TIME_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = POWER_W + CNT_W;

    // state and registers
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    logic               r_valid [TABLE_DEPTH];
    t_entry             r_mem [TABLE_DEPTH];
    t_entry             r_rd_data;
    logic               r_ev_vld;
    logic               r_ev_entry_valid;
    logic [IDX_W-1:0]   r_ev_idx;
    t_in_item           r_item;
    logic [TIME_W-1:0]  r_stale_limit;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_purged;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [TIME_W-1:0]  r_hit_last;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic [TOTAL_W-1:0] r_total;
    logic               r_out_valid;
    t_out_item          r_out_data;

    // control and datapath nets
    logic               in_xfer;
    logic               scan_en;
    logic               scan_last;
    logic               apply_go;
    logic               is_report;
    logic               stores;
    logic [TIME_W-1:0]  age_then;
    t_age_res           age_res;
    logic [SUM_W-1:0]   fin_sum;
    logic [CNT_W-1:0]   fin_cnt;
    logic [TOTAL_W-1:0] fin_total;
    t_out_item          fin_out;
    t_entry             wr_entry;
    logic [IDX_W-1:0]   wr_idx;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign is_report   = (r_item.cmd == CMD_REPORT);
    assign stores      = is_report && (r_hit || r_free_found);
    assign scan_last   = (r_idx == IDX_W'(TABLE_DEPTH - 1));

    // shared age unit: entry age while scanning, interval when applying
    assign age_then = (r_state == S_APPLY) ? r_hit_last : r_rd_data.last_seen;

    ptwa_age_unit u_age (
        .i_now   (r_item.now_ms),
        .i_then  (age_then),
        .i_limit (r_stale_limit),
        .o_res   (age_res)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        scan_en  = 1'b0;
        apply_go = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                scan_en = 1'b1;
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (!r_out_valid || !i_out_stall) begin
                    apply_go = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stale limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_limit <= STALE_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stale_limit <= i_cfg_data;
        end
    end

    // scan address and read pipe control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ev_vld <= 1'b0;
        end else begin
            r_ev_vld <= scan_en;
            if (in_xfer) begin
                r_idx <= '0;
            end else if (scan_en) begin
                r_idx <= scan_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    // entry memory with registered read
    always_ff @(posedge i_clk) begin
        r_rd_data        <= r_mem[r_idx];
        r_ev_idx         <= r_idx;
        r_ev_entry_valid <= r_valid[r_idx];
        if (apply_go && stores) begin
            r_mem[wr_idx] <= wr_entry;
        end
    end

    assign wr_idx             = r_hit ? r_hit_idx : r_free_idx;
    assign wr_entry.addr      = r_item.node_addr;
    assign wr_entry.power     = r_item.power_centi;
    assign wr_entry.prio      = r_item.priority_req;
    assign wr_entry.last_seen = r_item.now_ms;
    assign wr_entry.prev_seen = r_hit ? r_hit_last : '0;

    // valid bits: cleared by purge while scanning, set on insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (r_ev_vld && !is_report && r_ev_entry_valid && age_res.stale) begin
                r_valid[r_ev_idx] <= 1'b0;
            end
            if (apply_go && is_report && !r_hit && r_free_found) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // item capture and per-entry evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_cnt        <= '0;
            r_purged     <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (in_xfer) begin
            r_item       <= i_in_data;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_purged     <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_ev_vld) begin
            if (!is_report) begin
                // purge: stale entries go, the rest are summed
                if (r_ev_entry_valid) begin
                    if (age_res.stale) begin
                        r_purged <= r_purged + 1'b1;
                    end else begin
                        r_sum <= r_sum + SUM_W'(r_rd_data.power);
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end else if (r_ev_entry_valid) begin
                // report: matching entry is replaced, others are summed
                if (r_rd_data.addr == r_item.node_addr && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_ev_idx;
                    r_hit_last <= r_rd_data.last_seen;
                end else begin
                    r_sum <= r_sum + SUM_W'(r_rd_data.power);
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (!r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_ev_idx;
            end
        end
    end

    // result assembly
    assign fin_sum   = stores ? r_sum + SUM_W'(r_item.power_centi) : r_sum;
    assign fin_cnt   = stores ? r_cnt + 1'b1 : r_cnt;
    assign fin_total = (32'(fin_sum) > 32'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(fin_sum);

    always_comb begin
        if (!is_report) begin
            fin_out.status = ST_PURGED;
        end else if (r_hit) begin
            fin_out.status = ST_UPDATED;
        end else if (r_free_found) begin
            fin_out.status = ST_INSERTED;
        end else begin
            fin_out.status = ST_DROPPED;
        end
        fin_out.node_count = (32'(fin_cnt) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                             : COUNT_W'(fin_cnt);
        fin_out.total_centi        = fin_total;
        fin_out.report_interval_ms = (is_report && r_hit) ? age_res.diff : '0;
        fin_out.purged_count = (32'(r_purged) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                : COUNT_W'(r_purged);
    end

    // output register and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else if (apply_go) begin
            r_out_valid <= 1'b1;
            r_out_data  <= fin_out;
            r_total     <= fin_total;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // checks on the sequencer and results
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("scan did not start at entry zero after an input transfer");

    a_apply_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_go |=> o_out_valid && (o_out_data.total_centi == r_total))
        else $error("result register not loaded when the update was applied");

    a_eval_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_state == S_SCAN) || (r_state == S_DRAIN))
        else $error("entry evaluated outside the scan");

    a_purged_only_on_purge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_PURGED) |-> o_out_data.purged_count == '0)
        else $error("nonzero purged count on a report result");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.node_count) <= TABLE_DEPTH)
        else $error("live count exceeds the table depth");

endmodule
`default_nettype wire

/* tb/peer_table_check_pkg.sv */
// ----------------------------------------------------------------------------
// peer_table_check_pkg
// result predictor and scoreboard for the peer table with aging
// ----------------------------------------------------------------------------
// Holds its own copy of the node table and the stale limit. Each accepted
// item is run through the table model at once and its expected result
// queued. Results from the block are compared in order, field by field.
// ----------------------------------------------------------------------------
package peer_table_check_pkg;

    import ptwa_pkg::*;

    class peer_table_scoreboard;

        // mirrored table state
        bit                 entry_used      [TABLE_DEPTH_DEFAULT];
        logic [ADDR_W-1:0]  entry_node      [TABLE_DEPTH_DEFAULT];
        logic [POWER_W-1:0] entry_power     [TABLE_DEPTH_DEFAULT];
        logic [PRIO_W-1:0]  entry_prio      [TABLE_DEPTH_DEFAULT];
        logic [TIME_W-1:0]  entry_last_seen [TABLE_DEPTH_DEFAULT];
        logic [TIME_W-1:0]  entry_prev_seen [TABLE_DEPTH_DEFAULT];
        logic [TIME_W-1:0]  stale_limit;

        // expected results, oldest first
        t_out_item pending_results[$];
        int        failures;

        function new();
            int i;
            stale_limit = STALE_LIMIT_RESET;
            failures    = 0;
            for (i = 0; i < TABLE_DEPTH_DEFAULT; i++) begin
                entry_used[i] = 1'b0;
            end
        endfunction

        function void set_stale_limit(logic [TIME_W-1:0] value);
            stale_limit = value;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // apply one item to the table and work out its result
        function t_out_item predict_result(t_in_item item);
            t_out_item         res;
            int                i;
            int                hit;
            int                free_slot;
            int                live;
            int                purged;
            logic [31:0]       power_sum;
            logic [TIME_W-1:0] age;
            res       = '0;
            hit       = -1;
            free_slot = -1;
            purged    = 0;
            if (item.cmd == CMD_PURGE) begin
                // remove entries older than the limit, age wraps
                for (i = 0; i < TABLE_DEPTH_DEFAULT; i++) begin
                    age = item.now_ms - entry_last_seen[i];
                    if (entry_used[i] && age > stale_limit) begin
                        entry_used[i] = 1'b0;
                        purged++;
                    end
                end
                res.status = ST_PURGED;
            end else begin
                // look for the node, and for the lowest free slot
                for (i = 0; i < TABLE_DEPTH_DEFAULT; i++) begin
                    if (entry_used[i]) begin
                        if (hit < 0 && entry_node[i] == item.node_addr) hit = i;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit >= 0) begin
                    entry_power[hit]     = item.power_centi;
                    entry_prio[hit]      = item.priority_req;
                    entry_prev_seen[hit] = entry_last_seen[hit];
                    entry_last_seen[hit] = item.now_ms;
                    res.report_interval_ms = item.now_ms - entry_prev_seen[hit];
                    res.status = ST_UPDATED;
                end else if (free_slot >= 0) begin
                    entry_used[free_slot]      = 1'b1;
                    entry_node[free_slot]      = item.node_addr;
                    entry_power[free_slot]     = item.power_centi;
                    entry_prio[free_slot]      = item.priority_req;
                    entry_last_seen[free_slot] = item.now_ms;
                    entry_prev_seen[free_slot] = '0;
                    res.status = ST_INSERTED;
                end else begin
                    res.status = ST_DROPPED;
                end
            end

            // live count and total power, both saturating
            live      = 0;
            power_sum = '0;
            for (i = 0; i < TABLE_DEPTH_DEFAULT; i++) begin
                if (entry_used[i]) begin
                    live++;
                    power_sum = power_sum + entry_power[i];
                end
            end
            res.node_count   = (live > COUNT_MAX) ? COUNT_MAX : COUNT_W'(live);
            res.total_centi  = (power_sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(power_sum);
            res.purged_count = (purged > COUNT_MAX) ? COUNT_MAX : COUNT_W'(purged);
            return res;
        endfunction

        function void note_item(t_in_item item);
            pending_results.insert(pending_results.size(), predict_result(item));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                failures++;
                $display("%0t: result with nothing outstanding, expected none, got %h",
                         $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("node_count", want.node_count, got.node_count);
            compare_field("total_centi", want.total_centi, got.total_centi);
            compare_field("report_interval_ms", want.report_interval_ms,
                          got.report_interval_ms);
            compare_field("purged_count", want.purged_count, got.purged_count);
        endfunction

    endclass

endpackage

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// regression for the peer table with aging
// ----------------------------------------------------------------------------
// A directed run covers field extremes, updates with wrapping intervals,
// purges at the age boundary, wrapped ages, an empty table and a zero stale
// limit. Random phases then use small address pools so that nodes are hit
// again, the table fills and reports are dropped, under several stale limits.
// The sender works in bursts, the receiver stalls on its own pattern, and
// every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ptwa_pkg::*;
    import peer_table_check_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int POOL_SIZE     = 40;
    localparam int SETTLE_CYCLES = TABLE_DEPTH_DEFAULT + 8;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_item          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [TIME_W-1:0] cfg_data  = '0;

    peer_table_scoreboard board;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [TIME_W-1:0] clock_ms;
    int                burst_left  = 0;
    bit                sender_gaps = 1'b1;
    int                stall_mode  = 0;
    int                mode_left   = 0;
    int                stall_run   = 0;
    int                idle_cycles = 0;

    peer_table_with_aging #(
        .TABLE_DEPTH (TABLE_DEPTH_DEFAULT)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // clock
    always #2 clk = ~clk;

    // receiver stall pattern, switches among four random modes
    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_run == 0) begin
                    out_stall <= ~out_stall;
                    stall_run = $urandom_range(1, 20);
                end else begin
                    stall_run--;
                end
            end
        endcase
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    end

    // cycles with no transfer on any channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("peer_table_with_aging regression: fail");
        $finish;
    end

    // one item transfer, opening a new burst with a gap where due
    task automatic send_item(input t_in_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!sender_gaps) gap = 0;
            else if ($urandom_range(0, 4) == 0) gap = $urandom_range(20, 45);
            else gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_data  = item;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_item(item);
        @(negedge clk);
    endtask

    // stop sending and let every outstanding result arrive
    task automatic drain();
        in_valid   = 1'b0;
        burst_left = 0;
        while (board.outstanding() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_stale_limit(input logic [TIME_W-1:0] value);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        board.set_stale_limit(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic t_in_item make_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                                           input logic [POWER_W-1:0] power,
                                           input logic [PRIO_W-1:0] prio,
                                           input logic [TIME_W-1:0] now);
        t_in_item item;
        item.cmd          = cmd;
        item.node_addr    = addr;
        item.power_centi  = power;
        item.priority_req = prio;
        item.now_ms       = now;
        return item;
    endfunction

    function automatic logic [POWER_W-1:0] pick_power();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return POWER_W'($urandom);
        endcase
    endfunction

    // random reports over a small address pool, mixed with purges and noise
    task automatic run_random(input int n_items, input int unsigned step_max,
                              input int purge_pct, input int noise_pct);
        t_in_item item;
        bit       noise;
        int       k;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++) addr_pool[k] = ADDR_W'({$urandom, $urandom});
        clock_ms = $urandom;
        for (k = 0; k < n_items; k++) begin
            noise    = ($urandom_range(0, 99) < noise_pct);
            clock_ms = clock_ms + $urandom_range(0, step_max);
            item.cmd = ($urandom_range(0, 99) < purge_pct) ? CMD_PURGE : CMD_REPORT;
            item.node_addr = noise ? ADDR_W'({$urandom, $urandom})
                                   : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            item.power_centi  = pick_power();
            item.priority_req = PRIO_W'($urandom);
            item.now_ms       = noise ? TIME_W'($urandom) : clock_ms;
            send_item(item);
        end
        drain();
    endtask

    initial begin
        board = new();

        // reset
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, wrapping interval, boundary and wrapped ages
        send_item(make_item(CMD_REPORT, '0, '0, '0, 32'd0));
        send_item(make_item(CMD_REPORT, '1, '1, '1, 32'hFFFF_FFF0));
        send_item(make_item(CMD_REPORT, '0, '1, '1, 32'd10));
        send_item(make_item(CMD_REPORT, '1, '0, '0, 32'd5));
        send_item(make_item(CMD_REPORT, '1, 20'h12345, 8'h5A, 32'd5));
        send_item(make_item(CMD_PURGE, '1, '1, '1, 32'd6005));
        send_item(make_item(CMD_PURGE, '0, '0, '0, 32'd6006));
        send_item(make_item(CMD_REPORT, '1, 20'hABCDE, 8'hA5, 32'd6006));
        send_item(make_item(CMD_PURGE, '0, '0, '0, 32'd7));
        send_item(make_item(CMD_PURGE, '1, '1, '1, 32'd0));
        drain();

        // directed: zero stale limit purges any nonzero age
        write_stale_limit('0);
        send_item(make_item(CMD_REPORT, 48'h0123_4567_89AB, 20'h00100, 8'h01, 32'd500));
        send_item(make_item(CMD_REPORT, 48'hFEDC_BA98_7654, 20'hFFF00, 8'hFE, 32'd500));
        send_item(make_item(CMD_REPORT, 48'h0123_4567_89AB, 20'h55555, 8'h33, 32'd501));
        send_item(make_item(CMD_PURGE, '0, '0, '0, 32'd501));
        send_item(make_item(CMD_PURGE, '0, '0, '0, 32'd502));
        drain();

        // random phases under several stale limits
        write_stale_limit(32'd1);
        run_random(100, 2, 15, 0);

        // largest limit, nothing ages out so the table fills and drops
        write_stale_limit('1);
        run_random(120, 100000, 5, 0);

        write_stale_limit(STALE_LIMIT_RESET);
        run_random(130, 2500, 10, 5);

        write_stale_limit(TIME_W'($urandom));
        run_random(100, 50000000, 10, 5);

        write_stale_limit('0);
        run_random(80, 1, 20, 0);

        // back-to-back items with no sender gaps
        sender_gaps = 1'b0;
        write_stale_limit(STALE_LIMIT_RESET);
        run_random(120, 3000, 8, 15);

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.outstanding() == 0) begin
            $display("peer_table_with_aging regression: pass");
        end else begin
            $display("peer_table_with_aging regression: fail");
        end
        $finish;
    end

endmodule
